### design/aeti_pkg.sv
// Shared types, constants and codes for the azimuth/elevation track interpolator.
`default_nettype none

package aeti_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int TIME_W      = 48;
	localparam int AZ_W        = 25;
	localparam int EL_W        = 24;
	localparam int MAG_W       = 26;
	localparam int STEP_W      = $clog2(MAG_W);
	localparam int ANG_W       = 27;

	// Q.16 degrees
	localparam logic [AZ_W-1:0] DEG360 = AZ_W'(23592960);
	localparam logic [AZ_W-1:0] DEG180 = AZ_W'(11796480);

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK           = 2'd0,
		STAT_NOT_INCR     = 2'd1,
		STAT_FULL         = 2'd2,
		STAT_OUT_OF_TRACK = 2'd3
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0]      stamp;
		logic [AZ_W-1:0]        az;
		logic signed [EL_W-1:0] el;
	} point_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APP_RD,
		ST_APP_CHK,
		ST_Q_RD0,
		ST_Q_RD1,
		ST_Q_CHK,
		ST_SRCH,
		ST_SRCH_CMP,
		ST_FETCH_LO,
		ST_FETCH_HI,
		ST_SPAN,
		ST_AZ_PREP,
		ST_AZ_RUN,
		ST_EL_PREP,
		ST_EL_RUN,
		ST_OUT
	} fsm_state_t;

endpackage

`default_nettype wire

### design/aeti_point_mem.sv
// Point table memory: one write port, one read port with registered read data.
`default_nettype none

module aeti_point_mem
	import aeti_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire point_t           wr_data,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output point_t                rd_data
);

	point_t mem [TABLE_DEPTH];
	point_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### design/aeti_muldiv.sv
// Shared shift-add multiplier and restoring divider: quot = floor(mag * dt / span).
`default_nettype none

module aeti_muldiv
	import aeti_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MAG_W-1:0]  mag,
	input  wire logic [TIME_W-1:0] dt,
	input  wire logic [TIME_W-1:0] span,
	output logic                   done,
	output logic [MAG_W-1:0]       quot
);

	md_phase_t          phase_q, phase_d;
	logic [STEP_W-1:0]  step_q;
	logic               done_q;
	logic [TIME_W-1:0]  hi_q;
	logic [MAG_W-1:0]   lo_q;
	logic [TIME_W-1:0]  dt_q;
	logic [TIME_W-1:0]  span_q;

	logic               last;
	logic [TIME_W:0]    op_a;
	logic [TIME_W:0]    op_b;
	logic [TIME_W+1:0]  sum;
	logic               ge;
	logic [TIME_W:0]    acc;

	assign last = (step_q == STEP_W'(MAG_W - 1));

	// one adder/subtractor serves both phases
	always_comb begin
		op_a = (phase_q == MD_MUL) ? {1'b0, hi_q} : {hi_q, lo_q[MAG_W-1]};
		op_b = {1'b0, (phase_q == MD_MUL) ? dt_q : span_q};
		if (phase_q == MD_MUL) begin
			sum = {1'b0, op_a} + {1'b0, op_b};
		end else begin
			sum = {1'b0, op_a} - {1'b0, op_b};
		end
		ge  = ~sum[TIME_W+1];
		acc = lo_q[0] ? sum[TIME_W:0] : {1'b0, hi_q};
	end

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			MD_IDLE: begin
				if (start) begin
					phase_d = MD_MUL;
				end
			end
			MD_MUL: begin
				if (last) begin
					phase_d = MD_DIV;
				end
			end
			MD_DIV: begin
				if (last) begin
					phase_d = MD_IDLE;
				end
			end
			default: phase_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MD_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == MD_DIV) && last;
			if (phase_q == MD_IDLE || last) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			MD_IDLE: begin
				if (start) begin
					hi_q   <= '0;
					lo_q   <= mag;
					dt_q   <= dt;
					span_q <= span;
				end
			end
			MD_MUL: begin
				hi_q <= acc[TIME_W:1];
				lo_q <= {acc[0], lo_q[MAG_W-1:1]};
			end
			MD_DIV: begin
				hi_q <= ge ? sum[TIME_W-1:0] : op_a[TIME_W-1:0];
				lo_q <= {lo_q[MAG_W-2:0], ge};
			end
			default: begin
				hi_q <= hi_q;
			end
		endcase
	end

	assign done = done_q;
	assign quot = lo_q;

endmodule

`default_nettype wire

### design/azimuth_elevation_track_interpolator_top.sv
// Top level of the azimuth/elevation track interpolator: sequencer, table and result register.
// The block keeps up to 1024 time-stamped mount points (48-bit microsecond ticks, azimuth and
// elevation in Q.16 degrees) and handles one beat at a time: clear, append, or query. An append
// must carry a time strictly above the last stored one and finds room only while the table is
// not full. A query inside the stored span binary-searches the bracketing pair in the point
// memory, then interpolates azimuth (short way around, result kept in 0..360) and elevation
// with one shared shift-add multiplier / restoring divider, one pass per angle. A query first
// reads the first and last stored points, then runs the search, then makes the two passes
// through the divider. in_stall is high while a beat is in work; a finished result waits in
// the output register, so the next beat is taken even while out_stall holds the last result.
// No clearing pass is needed after reset: only entries below the point count are ever used.
`default_nettype none

module azimuth_elevation_track_interpolator_top
	import aeti_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             op,
	input  wire logic [TIME_W-1:0]      sample_time,
	input  wire logic [AZ_W-1:0]        azimuth_in,
	input  wire logic signed [EL_W-1:0] elevation_in,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [1:0]                  status,
	output logic [AZ_W-1:0]             azimuth_out,
	output logic signed [EL_W-1:0]      elevation_out
);

	localparam logic signed [ANG_W-1:0] DEG180_S = ANG_W'(DEG180);
	localparam logic signed [ANG_W-1:0] DEG360_S = ANG_W'(DEG360);

	fsm_state_t          state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;

	// beat being worked on
	op_t                 op_q;
	logic [TIME_W-1:0]   time_q;
	logic [AZ_W-1:0]     az_q;
	logic [EL_W-1:0]     el_q;

	// search window and bracket
	logic [IDX_W-1:0]    lo_idx_q;
	logic [IDX_W-1:0]    hi_idx_q;
	logic [IDX_W-1:0]    mid_q;
	point_t              lo_pt_q;
	point_t              hi_pt_q;
	logic [TIME_W-1:0]   span_q;
	logic [TIME_W-1:0]   dt_q;
	logic                neg_q;

	// pending result and output register
	status_t             res_status_q;
	logic [AZ_W-1:0]     res_az_q;
	logic [EL_W-1:0]     res_el_q;
	status_t             status_q;
	logic [AZ_W-1:0]     azimuth_out_q;
	logic [EL_W-1:0]     elevation_out_q;

	logic                accept;
	logic                out_free;
	logic                append_ok;
	logic                not_incr;
	logic                outside;
	logic [IDX_W-1:0]    last_idx;
	logic [IDX_W:0]      mid_sum;
	logic [IDX_W-1:0]    mid;
	logic [AZ_W-1:0]     az_reduced;

	// memory port
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	point_t              rd_data;
	logic                wr_en;
	point_t              wr_data;

	// shared divider
	logic                md_start;
	logic [MAG_W-1:0]    md_mag;
	logic                md_done;
	logic [MAG_W-1:0]    md_quot;

	// angle arithmetic
	logic signed [ANG_W-1:0] az_diff, az_wrap, az_mag;
	logic signed [ANG_W-1:0] el_lo_ext, el_hi_ext, el_diff, el_mag;
	logic signed [ANG_W-1:0] delta, az_sum, az_fix, el_sum;
	logic                    prep_neg;

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign last_idx  = IDX_W'(count_q - CNT_W'(1));
	assign mid_sum   = {1'b0, lo_idx_q} + {1'b0, hi_idx_q};
	assign mid       = mid_sum[IDX_W:1];
	assign az_reduced = (azimuth_in > DEG360) ? (azimuth_in - DEG360) : azimuth_in;

	assign not_incr  = (count_q != '0) && (time_q <= rd_data.stamp);
	assign append_ok = !not_incr && (count_q < CNT_W'(TABLE_DEPTH));
	assign outside   = (time_q < lo_pt_q.stamp) || (time_q > rd_data.stamp);

	assign wr_en           = (state_q == ST_APP_CHK) && append_ok;
	assign wr_data.stamp   = time_q;
	assign wr_data.az      = az_q;
	assign wr_data.el      = el_q;

	// angle differences (azimuth the short way around) and the interpolated results
	always_comb begin
		az_diff = ANG_W'(hi_pt_q.az) - ANG_W'(lo_pt_q.az);
		if (az_diff > DEG180_S) begin
			az_wrap = az_diff - DEG360_S;
		end else if (az_diff < -DEG180_S) begin
			az_wrap = az_diff + DEG360_S;
		end else begin
			az_wrap = az_diff;
		end
		az_mag = az_wrap[ANG_W-1] ? -az_wrap : az_wrap;

		el_lo_ext = {{(ANG_W-EL_W){lo_pt_q.el[EL_W-1]}}, lo_pt_q.el};
		el_hi_ext = {{(ANG_W-EL_W){hi_pt_q.el[EL_W-1]}}, hi_pt_q.el};
		el_diff   = el_hi_ext - el_lo_ext;
		el_mag    = el_diff[ANG_W-1] ? -el_diff : el_diff;

		if (state_q == ST_AZ_PREP) begin
			md_mag   = az_mag[MAG_W-1:0];
			prep_neg = az_wrap[ANG_W-1];
		end else begin
			md_mag   = el_mag[MAG_W-1:0];
			prep_neg = el_diff[ANG_W-1];
		end

		delta  = neg_q ? -ANG_W'(md_quot) : ANG_W'(md_quot);
		az_sum = ANG_W'(lo_pt_q.az) + delta;
		if (az_sum > DEG360_S) begin
			az_fix = az_sum - DEG360_S;
		end else if (az_sum < 0) begin
			az_fix = az_sum + DEG360_S;
		end else begin
			az_fix = az_sum;
		end
		el_sum = el_lo_ext + delta;
	end

	// sequencer: next state and memory/divider controls
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		md_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(op))
						OP_APPEND: state_d = ST_APP_RD;
						OP_QUERY:  state_d = (count_q == '0) ? ST_OUT : ST_Q_RD0;
						default:   state_d = ST_OUT;
					endcase
				end
			end
			ST_APP_RD: begin
				rd_en   = 1'b1;
				rd_addr = last_idx;
				state_d = ST_APP_CHK;
			end
			ST_APP_CHK: begin
				state_d = ST_OUT;
			end
			ST_Q_RD0: begin
				rd_en   = 1'b1;
				rd_addr = '0;
				state_d = ST_Q_RD1;
			end
			ST_Q_RD1: begin
				rd_en   = 1'b1;
				rd_addr = last_idx;
				state_d = ST_Q_CHK;
			end
			ST_Q_CHK: begin
				if (outside || count_q == CNT_W'(1)) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_SRCH;
				end
			end
			ST_SRCH: begin
				if (lo_idx_q == hi_idx_q) begin
					state_d = ST_FETCH_LO;
				end else begin
					rd_en   = 1'b1;
					rd_addr = mid;
					state_d = ST_SRCH_CMP;
				end
			end
			ST_SRCH_CMP: begin
				state_d = ST_SRCH;
			end
			ST_FETCH_LO: begin
				rd_en   = 1'b1;
				rd_addr = lo_idx_q - IDX_W'(1);
				state_d = ST_FETCH_HI;
			end
			ST_FETCH_HI: begin
				rd_en   = 1'b1;
				rd_addr = lo_idx_q;
				state_d = ST_SPAN;
			end
			ST_SPAN: begin
				state_d = ST_AZ_PREP;
			end
			ST_AZ_PREP: begin
				md_start = 1'b1;
				state_d  = ST_AZ_RUN;
			end
			ST_AZ_RUN: begin
				if (md_done) begin
					state_d = ST_EL_PREP;
				end
			end
			ST_EL_PREP: begin
				md_start = 1'b1;
				state_d  = ST_EL_RUN;
			end
			ST_EL_RUN: begin
				if (md_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && op_t'(op) == OP_CLEAR) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q         <= op_t'(op);
					time_q       <= sample_time;
					az_q         <= az_reduced;
					el_q         <= elevation_in;
					res_az_q     <= '0;
					res_el_q     <= '0;
					res_status_q <= (op_t'(op) == OP_QUERY && count_q == '0)
						? STAT_OUT_OF_TRACK : STAT_OK;
				end
			end
			ST_APP_CHK: begin
				if (not_incr) begin
					res_status_q <= STAT_NOT_INCR;
				end else if (!append_ok) begin
					res_status_q <= STAT_FULL;
				end
			end
			ST_Q_RD1: begin
				lo_pt_q <= rd_data;
			end
			ST_Q_CHK: begin
				lo_idx_q <= IDX_W'(1);
				hi_idx_q <= last_idx;
				if (outside) begin
					res_status_q <= STAT_OUT_OF_TRACK;
				end else if (count_q == CNT_W'(1)) begin
					res_az_q <= lo_pt_q.az;
					res_el_q <= lo_pt_q.el;
				end
			end
			ST_SRCH: begin
				mid_q <= mid;
			end
			ST_SRCH_CMP: begin
				// smallest index whose time is not below the query time
				if (rd_data.stamp >= time_q) begin
					hi_idx_q <= mid_q;
				end else begin
					lo_idx_q <= mid_q + IDX_W'(1);
				end
			end
			ST_FETCH_HI: begin
				lo_pt_q <= rd_data;
			end
			ST_SPAN: begin
				hi_pt_q <= rd_data;
				span_q  <= rd_data.stamp - lo_pt_q.stamp;
				dt_q    <= time_q - lo_pt_q.stamp;
			end
			ST_AZ_PREP, ST_EL_PREP: begin
				neg_q <= prep_neg;
			end
			ST_AZ_RUN: begin
				if (md_done) begin
					res_az_q <= az_fix[AZ_W-1:0];
				end
			end
			ST_EL_RUN: begin
				if (md_done) begin
					res_el_q <= el_sum[EL_W-1:0];
				end
			end
			ST_OUT: begin
				if (out_free) begin
					status_q        <= res_status_q;
					azimuth_out_q   <= res_az_q;
					elevation_out_q <= res_el_q;
				end
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	aeti_point_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	aeti_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.mag    (md_mag),
		.dt     (dt_q),
		.span   (span_q),
		.done   (md_done),
		.quot   (md_quot)
	);

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign azimuth_out   = azimuth_out_q;
	assign elevation_out = elevation_out_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("point count beyond table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("beat accepted but block not busy");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> azimuth_out == '0 && elevation_out == '0)
		else $error("nonzero angles on error status");

	a_az_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_q == OP_QUERY |-> azimuth_out <= DEG360)
		else $error("azimuth result outside 0..360");
`endif

endmodule

`default_nettype wire
